// ----- design/ols_pkg.sv -----
package ols_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 4;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int DATA_W   = 32;

	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;
	localparam logic [1:0] CMD_SEARCH = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic              ins;    // shift up from pos, load value at pos
		logic              del;    // shift down from pos
		logic [CMP_W-1:0]  pos;
		logic [CNT_W-1:0]  fill;   // entries held before this request
		logic [DATA_W-1:0] value;
	} cell_ctrl_t;

endpackage

// ----- design/ordered_list_store_top.sv -----
// ordered_list_store_top: bounded ordered list kept in a chain of entry cells.
// Result strobe (done): an accepted start passes the stage 1 and then the stage 2 registers.
// Throughput: one request per cycle; busy stays low, every cell shifts or
// compares in the same cycle, and the first-match encode sits in the second stage.
// Reset (arst_n low, asynchronous): list empty, no result pending.
// The receiver cannot stall: each result is shown for exactly one cycle.
module ordered_list_store_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [3:0]  position,
	input  logic signed [31:0] value,
	output logic        done,
	output logic [1:0]  status,
	output logic [3:0]  found_index,
	output logic [4:0]  count
);

	localparam int CAP = ols_pkg::CAPACITY;

	// fill count of the list
	logic [ols_pkg::CNT_W-1:0] fill_q;

	// decode of the request
	logic                      accept;
	logic                      full;
	logic [ols_pkg::CMP_W-1:0] pos_w;
	logic [ols_pkg::CMP_W-1:0] fill_w;
	logic [1:0]                st_now;
	logic [ols_pkg::CNT_W-1:0] fill_next;
	ols_pkg::cell_ctrl_t       ctrl;

	// cell chain
	logic [ols_pkg::DATA_W-1:0] cell_data [CAP];
	logic [CAP-1:0]             cell_match;

	// stage 1
	logic                      vld_s1;
	logic                      srch_s1;
	logic [1:0]                st_s1;
	logic [ols_pkg::CNT_W-1:0] cnt_s1;
	logic [CAP-1:0]            match_s1;

	// stage 2 / result registers
	logic                      done_q;
	logic [1:0]                status_q;
	logic [3:0]                found_q;
	logic [4:0]                count_q;

	// first-match encode
	logic [ols_pkg::IDX_W-1:0] hit_idx;
	logic                      hit_any;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (fill_q >= ols_pkg::CNT_W'(CAP));
	assign pos_w  = ols_pkg::CMP_W'(position);
	assign fill_w = ols_pkg::CMP_W'(fill_q);

	// status and shift request; search status is settled in stage 2
	always_comb begin
		st_now     = ols_pkg::ST_OK;
		fill_next  = fill_q;
		ctrl.ins   = 1'b0;
		ctrl.del   = 1'b0;
		ctrl.pos   = pos_w;
		ctrl.fill  = fill_q;
		ctrl.value = value;
		unique case (cmd)
			ols_pkg::CMD_APPEND: begin
				ctrl.pos = fill_w;
				if (full) begin
					st_now = ols_pkg::ST_FULL;
				end else begin
					ctrl.ins  = accept;
					fill_next = fill_q + ols_pkg::CNT_W'(1);
				end
			end
			ols_pkg::CMD_INSERT: begin
				priority if (full) begin
					st_now = ols_pkg::ST_FULL;
				end else if (pos_w > fill_w) begin
					st_now = ols_pkg::ST_RANGE;
				end else begin
					ctrl.ins  = accept;
					fill_next = fill_q + ols_pkg::CNT_W'(1);
				end
			end
			ols_pkg::CMD_DELETE: begin
				if (pos_w >= fill_w) begin
					st_now = ols_pkg::ST_RANGE;
				end else begin
					ctrl.del  = accept;
					fill_next = fill_q - ols_pkg::CNT_W'(1);
				end
			end
			ols_pkg::CMD_SEARCH: begin
				st_now = ols_pkg::ST_OK;
			end
			default: begin
				st_now = ols_pkg::ST_OK;
			end
		endcase
	end

	// chain: each cell sees its lower and upper neighbor; the ends see themselves
	for (genvar i = 0; i < CAP; i++) begin : g_cell
		logic [ols_pkg::DATA_W-1:0] left_d;
		logic [ols_pkg::DATA_W-1:0] right_d;
		if (i == 0) begin : g_lo
			assign left_d = cell_data[i];
		end else begin : g_lo_n
			assign left_d = cell_data[i-1];
		end
		if (i == CAP - 1) begin : g_hi
			assign right_d = cell_data[i];
		end else begin : g_hi_n
			assign right_d = cell_data[i+1];
		end
		ols_cell u_cell (
			.clk        (clk),
			.idx        (ols_pkg::IDX_W'(i)),
			.ctrl       (ctrl),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.match      (cell_match[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			if (accept) begin
				fill_q <= fill_next;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			srch_s1  <= (cmd == ols_pkg::CMD_SEARCH);
			st_s1    <= st_now;
			cnt_s1   <= fill_next;
			match_s1 <= cell_match;
		end
	end

	// lowest matching index
	always_comb begin
		hit_idx = '0;
		hit_any = |match_s1;
		for (int i = CAP - 1; i >= 0; i--) begin
			if (match_s1[i]) begin
				hit_idx = ols_pkg::IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			count_q <= 5'(cnt_s1);
			if (srch_s1) begin
				status_q <= hit_any ? ols_pkg::ST_OK : ols_pkg::ST_NOTFOUND;
				found_q  <= hit_any ? 4'(hit_idx) : 4'd0;
			end else begin
				status_q <= st_s1;
				found_q  <= 4'd0;
			end
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found_index = found_q;
	assign count       = count_q;

	// fill count stays within capacity
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= ols_pkg::CNT_W'(CAP))
		else $error("fill count above capacity");

	// a successful append grows the list by one
	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == ols_pkg::CMD_APPEND && !full)
		|=> fill_q == $past(fill_q) + ols_pkg::CNT_W'(1))
		else $error("append did not grow the list");

	// a full report is only given with the list at capacity
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ols_pkg::ST_FULL) |-> count == 5'(CAP))
		else $error("full status with list below capacity");

	// a nonzero found index only comes with a successful result
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found_index != 4'd0) |-> status == ols_pkg::ST_OK)
		else $error("found index on a failed request");

endmodule

// ----- design/ols_cell.sv -----
module ols_cell (
	input  logic                              clk,
	input  logic [ols_pkg::IDX_W-1:0]         idx,
	input  ols_pkg::cell_ctrl_t               ctrl,
	input  logic [ols_pkg::DATA_W-1:0]        left_data,
	input  logic [ols_pkg::DATA_W-1:0]        right_data,
	output logic [ols_pkg::DATA_W-1:0]        data,
	output logic                              match
);

	logic [ols_pkg::CMP_W-1:0] idx_w;
	logic [ols_pkg::CMP_W-1:0] fill_w;
	logic [ols_pkg::DATA_W-1:0] data_q;

	assign idx_w  = ols_pkg::CMP_W'(idx);
	assign fill_w = ols_pkg::CMP_W'(ctrl.fill);

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (idx_w == ctrl.pos) begin
				data_q <= ctrl.value;
			end else if (idx_w > ctrl.pos) begin
				data_q <= left_data;
			end
		end else if (ctrl.del) begin
			if (idx_w >= ctrl.pos) begin
				data_q <= right_data;
			end
		end
	end

	assign data  = data_q;
	assign match = (data_q == ctrl.value) && (idx_w < fill_w);

endmodule

// ----- tb/ols_list_checker.sv -----
`timescale 1ns / 100ps
// Watches the request and result ports of ordered_list_store_top, keeps a
// shadow copy of the list and checks every done strobe in order.
module ols_list_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         cmd,
	input  logic [3:0]         position,
	input  logic signed [31:0] value,
	input  logic               done,
	input  logic [1:0]         status,
	input  logic [3:0]         found_index,
	input  logic [4:0]         count,
	output int                 mismatches,
	output int                 outstanding
);

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] found;
		logic [4:0] count;
	} outcome_t;

	logic [31:0] shadow_list [ols_pkg::CAPACITY];
	int          shadow_fill;
	int          bad_total;
	outcome_t    awaited_outcomes [$];

	// shift up from slot 'at' and drop the value in
	function automatic void shadow_place(int at, logic [31:0] v);
		for (int i = shadow_fill; i > at; i--)
			shadow_list[i] = shadow_list[i-1];
		shadow_list[at] = v;
		shadow_fill++;
	endfunction

	function automatic outcome_t list_apply(logic [1:0] c, logic [3:0] p, logic [31:0] v);
		outcome_t o;
		logic     hit;
		o   = '0;
		hit = 1'b0;
		o.status = ols_pkg::ST_OK;
		case (c)
			ols_pkg::CMD_APPEND: begin
				if (shadow_fill >= ols_pkg::CAPACITY)
					o.status = ols_pkg::ST_FULL;
				else
					shadow_place(shadow_fill, v);
			end
			ols_pkg::CMD_INSERT: begin
				// full wins over a bad index
				if (shadow_fill >= ols_pkg::CAPACITY)
					o.status = ols_pkg::ST_FULL;
				else if (int'(p) > shadow_fill)
					o.status = ols_pkg::ST_RANGE;
				else
					shadow_place(int'(p), v);
			end
			ols_pkg::CMD_DELETE: begin
				if (int'(p) >= shadow_fill) begin
					o.status = ols_pkg::ST_RANGE;
				end else begin
					for (int i = int'(p); i + 1 < shadow_fill; i++)
						shadow_list[i] = shadow_list[i+1];
					shadow_fill--;
				end
			end
			default: begin
				for (int i = 0; i < shadow_fill; i++) begin
					if (!hit && shadow_list[i] == v) begin
						hit     = 1'b1;
						o.found = i[3:0];
					end
				end
				if (!hit)
					o.status = ols_pkg::ST_NOTFOUND;
			end
		endcase
		o.count = shadow_fill[4:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			shadow_fill = 0;
			bad_total   = 0;
			awaited_outcomes.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			// results first: the one leaving now was queued by an earlier accepted request
			if (done === 1'b1) begin
				if (awaited_outcomes.size() == 0) begin
					$display("%0t: unrequested result status %0d index %0d count %0d",
						$time, status, found_index, count);
					bad_total++;
				end else begin
					want = awaited_outcomes.pop_front();
					if (status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, status);
						bad_total++;
					end
					if (found_index !== want.found) begin
						$display("%0t: found_index expected %0d actual %0d",
							$time, want.found, found_index);
						bad_total++;
					end
					if (count !== want.count) begin
						$display("%0t: count expected %0d actual %0d",
							$time, want.count, count);
						bad_total++;
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				awaited_outcomes.push_back(list_apply(cmd, position, value));
			mismatches  <= bad_total;
			outstanding <= awaited_outcomes.size();
		end
	end

endmodule

// ----- tb/tb_ordered_list_store_top.sv -----
`timescale 1ns / 100ps
// Top of the list store bench: drives requests, lets the checker judge the
// results, and prints the verdict.
module tb_ordered_list_store_top;

	localparam int RANDOM_REQUESTS = 2000;
	localparam int BLOCK_LEN       = 64;     // requests per traffic phase
	localparam int CYCLE_LIMIT     = 200000; // many times what all the requests need
	localparam int DRAIN_CYCLES    = 8;      // done lags acceptance by the stage 1 and stage 2 registers

	// traffic phases: grow pushes the list to full, shrink drains it to empty
	typedef enum logic [1:0] {PH_GROW, PH_SHRINK, PH_MIXED} traffic_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         cmd;
	logic [3:0]         position;
	logic signed [31:0] value;
	logic               done;
	logic [1:0]         status;
	logic [3:0]         found_index;
	logic [4:0]         count;

	int   mismatches;
	int   outstanding;
	int   cycles = 0;
	logic no_gaps;

	ordered_list_store_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.position    (position),
		.value       (value),
		.done        (done),
		.status      (status),
		.found_index (found_index),
		.count       (count)
	);

	ols_list_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.position    (position),
		.value       (value),
		.done        (done),
		.status      (status),
		.found_index (found_index),
		.count       (count),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	// hard stop in case the block hangs or drops a strobe
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_ordered_list_store_top: errors");
			$finish;
		end
	end

	// Small pool so searches hit and duplicates exercise first-match;
	// the rest are full-range random words.
	function automatic logic [31:0] pick_value();
		logic [31:0] pool [8];
		pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h0000_0001, 32'h0000_0005, 32'h5555_5555, 32'hAAAA_AAAA};
		if ($urandom_range(0, 9) < 4)
			return pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	function automatic logic [1:0] pick_cmd(traffic_t ph);
		int r;
		r = $urandom_range(0, 99);
		case (ph)
			PH_GROW:   return (r < 45) ? ols_pkg::CMD_APPEND :
				(r < 85) ? ols_pkg::CMD_INSERT :
				(r < 92) ? ols_pkg::CMD_DELETE : ols_pkg::CMD_SEARCH;
			PH_SHRINK: return (r < 10) ? ols_pkg::CMD_APPEND :
				(r < 20) ? ols_pkg::CMD_INSERT :
				(r < 75) ? ols_pkg::CMD_DELETE : ols_pkg::CMD_SEARCH;
			default:   return (r < 25) ? ols_pkg::CMD_APPEND :
				(r < 50) ? ols_pkg::CMD_INSERT :
				(r < 75) ? ols_pkg::CMD_DELETE : ols_pkg::CMD_SEARCH;
		endcase
	endfunction

	// One request. Called just after an edge; drives on the next falling
	// edge after an optional idle gap, then holds until the block takes it.
	// start is left high so back-to-back requests need no extra write.
	task automatic issue(input logic [1:0] c, input logic [3:0] p, input logic [31:0] v);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start    = 1'b1;
		cmd      = c;
		position = p;
		value    = v;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	initial begin
		traffic_t ph;
		int       k;
		start    = 1'b0;
		cmd      = ols_pkg::CMD_APPEND;
		position = '0;
		value    = '0;
		no_gaps  = 1'b0;
		ph       = PH_MIXED;
		arst_n   = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// --- directed: empty list corners ---
		issue(ols_pkg::CMD_DELETE, 4'd0, 32'h0);            // delete on empty -> range
		issue(ols_pkg::CMD_SEARCH, 4'd0, 32'h0);            // search on empty -> not found
		issue(ols_pkg::CMD_INSERT, 4'd1, 32'h1);            // insert past end -> range
		issue(ols_pkg::CMD_INSERT, 4'd0, 32'h7FFF_FFFF);    // insert into empty slot 0
		issue(ols_pkg::CMD_APPEND, 4'd15, 32'h8000_0000);   // position ignored by append
		issue(ols_pkg::CMD_INSERT, 4'd2, 32'hFFFF_FFFF);    // position == count appends
		issue(ols_pkg::CMD_INSERT, 4'd0, 32'h0);            // shift everything up
		issue(ols_pkg::CMD_SEARCH, 4'd9, 32'h8000_0000);    // hit in the middle
		issue(ols_pkg::CMD_SEARCH, 4'd0, 32'h0001_2345);    // miss on a non-empty list
		issue(ols_pkg::CMD_DELETE, 4'd4, 32'h0);            // delete at count -> range
		issue(ols_pkg::CMD_DELETE, 4'd15, 32'h0);           // max position -> range
		issue(ols_pkg::CMD_DELETE, 4'd0, 32'h0);            // delete head, shift down

		// --- directed: fill to capacity, with a duplicate of -1 ---
		for (k = 0; k < 13; k++)
			issue(ols_pkg::CMD_APPEND, 4'($urandom),
				(k == 5) ? 32'hFFFF_FFFF : pick_value());
		issue(ols_pkg::CMD_APPEND, 4'd0, 32'h1234_5678);    // append when full
		issue(ols_pkg::CMD_INSERT, 4'd15, 32'h1234_5678);   // full is reported before range
		issue(ols_pkg::CMD_SEARCH, 4'd0, 32'hFFFF_FFFF);    // first of two matches
		issue(ols_pkg::CMD_DELETE, 4'd15, 32'h0);           // delete tail of a full list
		issue(ols_pkg::CMD_INSERT, 4'd15, 32'h5555_5555);   // refill at the last slot

		// --- random: phases of growth, drain and mixed traffic ---
		for (k = 0; k < RANDOM_REQUESTS; k++) begin
			if (k % BLOCK_LEN == 0) begin
				ph      = traffic_t'($urandom_range(0, 2));
				no_gaps = ($urandom_range(0, 3) == 0);
			end
			issue(pick_cmd(ph), 4'($urandom_range(0, 15)), pick_value());
		end

		@(negedge clk);
		start = 1'b0;

		// let every result come home, then a few quiet cycles for strays
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("tb_ordered_list_store_top: clean");
		else
			$display("tb_ordered_list_store_top: errors");
		$finish;
	end

endmodule
